@@ hdl/glu_pkg.sv @@
package glu_pkg;

	localparam int NUM_STOPS = 16;
	localparam int COMPRESS_TABLE_BITS = 12;
	localparam int IDX_W = $clog2(NUM_STOPS);
	localparam int CNT_W = $clog2(NUM_STOPS + 1);
	localparam int LIN_SHIFT = 16 - COMPRESS_TABLE_BITS;

	localparam logic [1:0] REG_NUM_STOPS = 2'd0;
	localparam logic [1:0] REG_MAX_VALUE = 2'd1;
	localparam logic [1:0] REG_AREA_TOP = 2'd2;
	localparam logic [1:0] REG_AREA_HEIGHT = 2'd3;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic req_type;
		logic [3:0] stop_index;
		logic [7:0] stop_red;
		logic [7:0] stop_green;
		logic [7:0] stop_blue;
		logic [23:0] stop_position;
		logic signed [15:0] y_coord;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic color_valid;
	} out_item_t;

	typedef logic [255:0][16:0] expand_tab_t;

	// Linear-light value of an 8-bit code in Q1.16, built from a fifth root in Q0.12.
	function automatic logic [16:0] expand_val(input int c);
		logic [63:0] hi;
		logic [63:0] t;
		logic [63:0] lo;
		logic [63:0] up;
		logic [63:0] mid;
		logic [63:0] p;
		hi = 64'(c) << 56;
		t = (hi / 64'd255) * 64'd16 + ((hi % 64'd255) * 64'd16) / 64'd255;
		lo = 64'd0;
		up = 64'd4096;
		for (int k = 0; k < 14; k++) begin
			if (lo < up) begin
				mid = (lo + up + 64'd1) >> 1;
				p = mid * mid * mid * mid * mid;
				if (p <= t) begin
					lo = mid;
				end else begin
					up = mid - 64'd1;
				end
			end
		end
		return 17'((64'(c) * 64'(c) * lo * 64'd16) / 64'd65025);
	endfunction

	function automatic expand_tab_t build_expand();
		expand_tab_t tab;
		for (int c = 0; c < 256; c++) begin
			tab[c] = expand_val(c);
		end
		return tab;
	endfunction

	localparam expand_tab_t EXPAND = build_expand();

endpackage

@@ hdl/glu_mul.sv @@
module glu_mul (
	input logic clk,
	input logic signed [24:0] a,
	input logic signed [17:0] b,
	output logic signed [42:0] prod_q
);
	always_ff @(posedge clk) begin
		prod_q <= 43'(a * b);
	end
endmodule

@@ hdl/gamma_correct_gradient_lookup_unit.sv @@
// Gradient stop table with gamma-correct color lookup.
// A stop write is taken with no result and no stall, so writes can follow back to back.
// A query stalls the input through map, NV, scan, a 16-step divide, the per-channel mix and the
// result state, longer while an earlier result beat is still stalled. The scan reads each stop
// in use in turn; divide and mix (8 search steps per channel) run only with both stops.
// Reset clears the sequencer and the registers to 0, 65536, 0, 256; stop entries are undefined.
module gamma_correct_gradient_lookup_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input glu_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output glu_pkg::out_item_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import glu_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MAP = 9'b000000010,
		S_NV = 9'b000000100,
		S_SCAN = 9'b000001000,
		S_DIV = 9'b000010000,
		S_MULT = 9'b000100000,
		S_LIN = 9'b001000000,
		S_SRCH = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t state_q;

	logic [4:0] num_stops_q;
	logic [23:0] max_value_q;
	logic [14:0] area_top_q;
	logic [14:0] area_height_q;

	logic [23:0] stop_col_q [NUM_STOPS];
	logic [23:0] stop_pos_q [NUM_STOPS];

	logic signed [15:0] y_q;
	logic [14:0] d_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [40:0] nv_q;
	logic [23:0] pos_s1;
	logic [23:0] col_s1;
	logic vld_s1;
	logic [23:0] upv_q;
	logic [24:0] dnv_q;
	logic [38:0] upd_q;
	logic [38:0] dnd_q;
	logic [23:0] upc_q;
	logic [23:0] dnc_q;
	logic upf_q;
	logic dnf_q;
	logic [38:0] rem_q;
	logic [38:0] den_q;
	logic [15:0] w_q;
	logic [3:0] step_q;
	logic [1:0] ch_q;
	logic [16:0] x_q;
	logic [7:0] lo_q;
	logic [7:0] res_q [3];
	logic out_valid_q;
	out_item_t out_data_q;

	logic signed [24:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [42:0] prod_q;

	logic cfg_wr;
	logic in_acc;
	logic issue;
	logic [38:0] pd;
	logic prod_lt;
	logic prod_gt;
	logic [7:0] ca;
	logic [7:0] cb;
	logic [17:0] diff;
	logic [17:0] lin;
	logic [39:0] r2;
	logic [7:0] cand;
	logic [16:0] y_minus_top;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_comb begin
		unique case (paddr[3:2])
			REG_NUM_STOPS: prdata = {27'd0, num_stops_q};
			REG_MAX_VALUE: prdata = {8'd0, max_value_q};
			REG_AREA_TOP: prdata = {17'd0, area_top_q};
			REG_AREA_HEIGHT: prdata = {17'd0, area_height_q};
			default: prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_stops_q <= 5'd0;
			max_value_q <= 24'd65536;
			area_top_q <= 15'd0;
			area_height_q <= 15'd256;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_NUM_STOPS: num_stops_q <= pwdata[4:0];
				REG_MAX_VALUE: max_value_q <= pwdata[23:0];
				REG_AREA_TOP: area_top_q <= pwdata[14:0];
				REG_AREA_HEIGHT: area_height_q <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_data.req_type == REQ_WRITE && 32'(in_data.stop_index) < NUM_STOPS) begin
			stop_col_q[IDX_W'(in_data.stop_index)] <=
				{in_data.stop_red, in_data.stop_green, in_data.stop_blue};
			stop_pos_q[IDX_W'(in_data.stop_index)] <= in_data.stop_position;
		end
	end

	assign issue = (cnt_q < n_q);
	assign pd = prod_q[38:0];
	assign prod_lt = $signed({3'b000, pd}) < $signed({nv_q[40], nv_q});
	assign prod_gt = $signed({3'b000, pd}) > $signed({nv_q[40], nv_q});
	assign y_minus_top = 17'($signed({y_q[15], y_q}) - $signed({2'b00, area_top_q}));

	always_comb begin
		case (ch_q)
			2'd0: begin
				ca = upc_q[23:16];
				cb = dnc_q[23:16];
			end
			2'd1: begin
				ca = upc_q[15:8];
				cb = dnc_q[15:8];
			end
			default: begin
				ca = upc_q[7:0];
				cb = dnc_q[7:0];
			end
		endcase
	end

	assign diff = {1'b0, EXPAND[cb]} - {1'b0, EXPAND[ca]};
	// Mixing as Ea + (Eb - Ea) * w / 65536 gives the same floor as the two-product form.
	assign lin = {1'b0, EXPAND[ca]} + 18'(prod_q >>> 16);
	assign r2 = {rem_q, 1'b0};
	assign cand = lo_q | (8'd1 << step_q[2:0]);

	always_comb begin
		mul_a = 25'sd0;
		mul_b = 18'sd0;
		unique case (state_q)
			S_MAP: begin
				mul_a = $signed({1'b0, max_value_q});
				mul_b = $signed({y_minus_top[16], y_minus_top});
			end
			S_SCAN: begin
				mul_a = $signed({1'b0, stop_pos_q[cnt_q[IDX_W-1:0]]});
				mul_b = $signed({3'b000, d_q});
			end
			S_MULT: begin
				mul_a = $signed({{7{diff[17]}}, diff});
				mul_b = $signed({2'b00, w_q});
			end
			default: ;
		endcase
	end

	glu_mul u_mul (
		.clk(clk),
		.a(mul_a),
		.b(mul_b),
		.prod_q(prod_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && in_data.req_type == REQ_QUERY) begin
						state_q <= S_MAP;
					end
				end
				S_MAP: state_q <= S_NV;
				S_NV: state_q <= S_SCAN;
				S_SCAN: begin
					vld_s1 <= issue;
					if (!issue && !vld_s1) begin
						state_q <= (upf_q && dnf_q) ? S_DIV : S_DONE;
					end
				end
				S_DIV: begin
					if (step_q == 4'd15) begin
						state_q <= S_MULT;
					end
				end
				S_MULT: state_q <= S_LIN;
				S_LIN: state_q <= S_SRCH;
				S_SRCH: begin
					if (step_q[2:0] == 3'd0) begin
						state_q <= (ch_q == 2'd2) ? S_DONE : S_MULT;
					end
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				y_q <= in_data.y_coord;
				d_q <= (area_height_q == 15'd0) ? 15'd1 : area_height_q;
				n_q <= (32'(num_stops_q) < NUM_STOPS) ? CNT_W'(num_stops_q) : CNT_W'(NUM_STOPS);
				cnt_q <= '0;
				upv_q <= 24'd0;
				dnv_q <= 25'd65536;
				upf_q <= 1'b0;
				dnf_q <= 1'b0;
				ch_q <= 2'd0;
			end
			S_NV: nv_q <= prod_q[40:0];
			S_SCAN: begin
				pos_s1 <= stop_pos_q[cnt_q[IDX_W-1:0]];
				col_s1 <= stop_col_q[cnt_q[IDX_W-1:0]];
				if (issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (vld_s1) begin
					if (pos_s1 >= upv_q && prod_lt) begin
						upv_q <= pos_s1;
						upd_q <= pd;
						upc_q <= col_s1;
						upf_q <= 1'b1;
					end
					if ({1'b0, pos_s1} <= dnv_q && prod_gt) begin
						dnv_q <= {1'b0, pos_s1};
						dnd_q <= pd;
						dnc_q <= col_s1;
						dnf_q <= 1'b1;
					end
				end
				rem_q <= 39'(nv_q - $signed({2'b00, upd_q}));
				den_q <= dnd_q - upd_q;
				step_q <= 4'd0;
			end
			S_DIV: begin
				// Restoring division, one quotient bit per cycle; the numerator stays below den.
				if (r2 >= {1'b0, den_q}) begin
					rem_q <= 39'(r2 - {1'b0, den_q});
					w_q <= {w_q[14:0], 1'b1};
				end else begin
					rem_q <= r2[38:0];
					w_q <= {w_q[14:0], 1'b0};
				end
				step_q <= step_q + 4'd1;
			end
			S_LIN: begin
				x_q <= (lin[16:0] >> LIN_SHIFT) << LIN_SHIFT;
				lo_q <= 8'd0;
				step_q <= 4'd7;
			end
			S_SRCH: begin
				// Largest code whose linear value is at or below the quantized level.
				if (EXPAND[cand] <= x_q) begin
					lo_q <= cand;
				end
				step_q <= step_q - 4'd1;
				if (step_q[2:0] == 3'd0) begin
					res_q[ch_q] <= (EXPAND[cand] <= x_q) ? cand : lo_q;
					ch_q <= ch_q + 2'd1;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					if (upf_q && dnf_q) begin
						out_data_q <= {res_q[0], res_q[1], res_q[2], 1'b1};
					end else if (upf_q) begin
						out_data_q <= {upc_q, 1'b1};
					end else if (dnf_q) begin
						out_data_q <= {dnc_q, 1'b1};
					end else begin
						out_data_q <= '0;
					end
				end
			end
			default: ;
		endcase
	end

endmodule

@@ hdl/glu_checker.sv @@
module glu_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input glu_pkg::in_item_t in_data,
	input logic out_valid,
	input logic out_stall,
	input glu_pkg::out_item_t out_data,
	input logic pready
);
	import glu_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.req_type == REQ_QUERY |=> in_stall)
		else $error("query accepted without going busy");

	a_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.req_type == REQ_WRITE && !out_valid |=>
		!in_stall && !out_valid)
		else $error("stop write produced a result or stalled");

	a_invalid_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.color_valid |->
		out_data.out_red == 8'd0 && out_data.out_green == 8'd0 && out_data.out_blue == 8'd0)
		else $error("invalid colour is not black");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind gamma_correct_gradient_lookup_unit glu_checker u_glu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.in_data(in_data),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data),
	.pready(pready)
);

@@ bench/gamma_correct_gradient_lookup_unit_test.sv @@
module gamma_correct_gradient_lookup_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import glu_pkg::*;

	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;

	// Golden gradient model: stop table, registers and the gamma tables.
	class gradient_scoreboard;
		logic [23:0] colors[16];
		logic [23:0] positions[16];
		int unsigned stop_count;
		longint unsigned peak_value;
		longint unsigned top_row;
		longint unsigned row_span;
		longint unsigned linear_of[256];
		int unsigned code_of[4096];
		out_item_t pending_colors[$];
		int errors;

		function new();
			longint unsigned hi, t, lo, up, mid;
			int unsigned k;
			stop_count = 0;
			peak_value = 65536;
			top_row = 0;
			row_span = 256;
			errors = 0;
			for (int c = 0; c < 256; c++) begin
				hi = longint'(c) << 56;
				t = (hi / 255) * 16 + ((hi % 255) * 16) / 255;
				lo = 0;
				up = 4096;
				while (lo < up) begin
					mid = (lo + up + 1) >> 1;
					if (mid * mid * mid * mid * mid <= t) lo = mid;
					else up = mid - 1;
				end
				linear_of[c] = (longint'(c) * c * lo * 16) / 65025;
			end
			k = 0;
			for (int j = 0; j < 4096; j++) begin
				while (k < 255 && linear_of[k + 1] <= longint'(j) << 4) k++;
				code_of[j] = k;
			end
		endfunction

		function void set_register(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_NUM_STOPS: stop_count = 32'(val[4:0]);
				REG_MAX_VALUE: peak_value = 64'(val[23:0]);
				REG_AREA_TOP: top_row = 64'(val[14:0]);
				default: row_span = 64'(val[14:0]);
			endcase
		endfunction

		function logic [7:0] blend(logic [7:0] a, logic [7:0] b, longint unsigned w);
			longint unsigned lin;
			lin = (linear_of[a] * (65536 - w) + linear_of[b] * w) >> 16;
			if ((lin >> 4) >= 4096) return 8'd255;
			return 8'(code_of[lin >> 4]);
		endfunction

		function void note_beat(in_item_t it);
			longint y, nv, d, p, above_pos, below_pos, w;
			logic [23:0] above_col, below_col;
			bit got_above, got_below;
			int n;
			out_item_t r;
			if (it.req_type == REQ_WRITE) begin
				colors[it.stop_index] = {it.stop_red, it.stop_green, it.stop_blue};
				positions[it.stop_index] = it.stop_position;
				return;
			end
			y = longint'(it.y_coord);
			d = (row_span == 0) ? 1 : longint'(row_span);
			nv = longint'(peak_value) * (y - longint'(top_row));
			n = (stop_count < 16) ? stop_count : 16;
			above_pos = 0;
			below_pos = 65536;
			got_above = 0;
			got_below = 0;
			above_col = 0;
			below_col = 0;
			for (int i = 0; i < n; i++) begin
				p = longint'(positions[i]);
				if (p >= above_pos && p * d < nv) begin
					above_pos = p; above_col = colors[i]; got_above = 1;
				end
				if (p <= below_pos && p * d > nv) begin
					below_pos = p; below_col = colors[i]; got_below = 1;
				end
			end
			r = '0;
			if (got_above && got_below) begin
				w = ((nv - above_pos * d) << 16) / ((below_pos - above_pos) * d);
				r.out_red = blend(above_col[23:16], below_col[23:16], w);
				r.out_green = blend(above_col[15:8], below_col[15:8], w);
				r.out_blue = blend(above_col[7:0], below_col[7:0], w);
				r.color_valid = 1'b1;
			end else if (got_above || got_below) begin
				{r.out_red, r.out_green, r.out_blue} = got_above ? above_col : below_col;
				r.color_valid = 1'b1;
			end
			pending_colors = {pending_colors, r};
		endfunction

		task report(string what, int got, int want);
			$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
			errors++;
		endtask

		task check_beat(out_item_t got);
			out_item_t want;
			if (pending_colors.size() == 0) begin
				report("unexpected beat", 1, 0);
				return;
			end
			want = pending_colors.pop_front();
			if (got.out_red !== want.out_red) report("red", got.out_red, want.out_red);
			if (got.out_green !== want.out_green)
				report("green", got.out_green, want.out_green);
			if (got.out_blue !== want.out_blue) report("blue", got.out_blue, want.out_blue);
			if (got.color_valid !== want.color_valid)
				report("color_valid", got.color_valid, want.color_valid);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	out_item_t out_data;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	gradient_scoreboard board = new();
	int quiet_cycles = 0;
	int hold_token = 0;
	bit written[16];

	gamma_correct_gradient_lookup_unit i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Receiver: a random wait before each result beat, one long hold-off on request.
	initial begin
		int gap;
		int hold_ack;
		hold_ack = 0;
		@(negedge clk);
		forever begin
			gap = $urandom_range(0, 3);
			if (hold_token != hold_ack) begin
				hold_ack = hold_token;
				gap = HOLD_CYCLES;
			end
			out_stall <= (gap != 0);
			repeat (gap) @(negedge clk);
			if (gap != 0) out_stall <= 0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) board.check_beat(out_data);
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > QUIET_LIMIT) begin
			$display("gamma_correct_gradient_lookup_unit test failed");
			$finish;
		end
	end

	// The valid stays high after a beat until the next beat or an idle gap replaces it.
	task send_beat(in_item_t it, int gap);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		board.note_beat(it);
		@(negedge clk);
	endtask

	task write_register(logic [1:0] idx, logic [31:0] val);
		psel <= 1;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.set_register(idx, val);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		@(negedge clk);
	endtask

	task drain();
		in_valid <= 0;
		while (board.pending_colors.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	function in_item_t stop_beat(int idx, logic [23:0] pos);
		in_item_t it;
		it = '0;
		it.req_type = REQ_WRITE;
		it.stop_index = 4'(idx);
		{it.stop_red, it.stop_green, it.stop_blue} = 24'($urandom);
		it.stop_position = pos;
		it.y_coord = 16'($urandom);
		return it;
	endfunction

	function in_item_t query_beat(logic [15:0] y);
		in_item_t it;
		it = stop_beat(0, 24'd0);
		it.stop_index = 4'($urandom);
		it.stop_position = 24'($urandom);
		it.req_type = REQ_QUERY;
		it.y_coord = y;
		return it;
	endfunction

	function logic [23:0] random_position();
		case ($urandom_range(0, 5))
			0: return 24'hFFFFFF;
			1: return 24'd0;
			2: return 24'd65536;
			3: return 24'($urandom);
			default: return 24'($urandom_range(0, 65536));
		endcase
	endfunction

	task random_phase(int count, logic [4:0] stops, logic [23:0] peak,
			logic [14:0] top, logic [14:0] span);
		int used;
		in_item_t it;
		drain();
		write_register(REG_NUM_STOPS, 32'(stops));
		write_register(REG_MAX_VALUE, 32'(peak));
		write_register(REG_AREA_TOP, 32'(top));
		write_register(REG_AREA_HEIGHT, 32'(span));
		used = (stops > 16) ? 16 : stops;
		// Every scanned entry gets written before the first query.
		for (int i = 0; i < used; i++) begin
			if (!written[i]) begin
				send_beat(stop_beat(i, random_position()), $urandom_range(0, 3));
				written[i] = 1;
			end
		end
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 3) == 0) begin
				it = stop_beat($urandom_range(0, 15), random_position());
				written[it.stop_index] = 1;
			end else if ($urandom_range(0, 7) == 0) begin
				it = query_beat(16'($urandom));
			end else begin
				it = query_beat(16'(int'(top) + $urandom_range(0, span + 2) - 1));
			end
			if ($urandom_range(0, 4) == 0) send_beat(it, 0);
			else send_beat(it, $urandom_range(0, 3));
		end
	endtask

	initial begin
		in_item_t it;
		for (int i = 0; i < 16; i++) written[i] = 0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: nothing scanned, then field extremes and bracket cases.
		send_beat(query_beat(16'h7FFF), 0);
		send_beat(query_beat(16'h8000), 0);
		drain();
		write_register(REG_NUM_STOPS, 32'd31);
		send_beat(stop_beat(0, 24'd0), 0);
		send_beat(stop_beat(1, 24'd65536), 0);
		send_beat(stop_beat(2, 24'd32768), 1);
		send_beat(stop_beat(3, 24'd32768), 0);
		it = stop_beat(4, 24'hFFFFFF);
		it.stop_red = 8'hFF; it.stop_green = 8'hFF; it.stop_blue = 8'hFF;
		send_beat(it, 0);
		it.stop_index = 5; it.stop_position = 24'd16384;
		it.stop_red = 0; it.stop_green = 0; it.stop_blue = 0;
		send_beat(it, 0);
		for (int i = 6; i < 16; i++) send_beat(stop_beat(i, 24'($urandom_range(0, 65536))), 0);
		for (int i = 0; i < 16; i++) written[i] = 1;
		send_beat(query_beat(16'd0), 0);
		send_beat(query_beat(16'd128), 2);
		send_beat(query_beat(16'd64), 0);
		send_beat(query_beat(16'd256), 0);
		send_beat(query_beat(16'd300), 0);
		send_beat(query_beat(16'hFFFF), 0);
		send_beat(query_beat(16'd77), 3);

		// Long receiver hold-off while the sender keeps going.
		hold_token = hold_token + 1;
		for (int k = 0; k < 12; k++) send_beat(query_beat(16'($urandom_range(0, 256))), 0);

		random_phase(300, 5'd16, 24'd65536, 15'd0, 15'd256);
		random_phase(250, 5'd2, 24'hFFFFFF, 15'h7FFF, 15'h7FFF);
		random_phase(250, 5'd0, 24'd1, 15'd0, 15'd1);
		random_phase(250, 5'd20, 24'd65536, 15'd100, 15'd0);
		random_phase(300, 5'd8, 24'd200000, 15'd10, 15'd37);
		random_phase(300, 5'd16, 24'd65536, 15'd1000, 15'd3);

		drain();
		if (board.errors == 0 && board.pending_colors.size() == 0) begin
			$display("gamma_correct_gradient_lookup_unit test passed");
		end else begin
			$display("gamma_correct_gradient_lookup_unit test failed");
		end
		$finish;
	end

endmodule
